// ----- design/auto_ranging_audio_bar_meter_unit_assert.svh -----
// Assertion macros for the bar meter checker.
`ifndef AUTO_RANGING_AUDIO_BAR_METER_UNIT_ASSERT_SVH
`define AUTO_RANGING_AUDIO_BAR_METER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ARBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ARBM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- design/arbm_pkg.sv -----
// Package: shared types and constants of the bar meter.
`default_nettype none
package arbm_pkg;
    localparam int unsigned SampleW = 10;
    localparam int unsigned AvgW    = 11;
    localparam int unsigned HeightW = 7;

    localparam logic [1:0] REG_LED_COUNT   = 2'd0;
    localparam logic [1:0] REG_CENTER_TRIM = 2'd1;
    localparam logic [1:0] REG_NOISE_FLOOR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FRONT,
        ST_DIV,
        ST_EMIT,
        ST_WRITE,
        ST_SCAN,
        ST_AVG
    } state_t;

    typedef struct packed {
        logic start;
        logic [15:0] num;
        logic [10:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [15:0] quot;
    } div_rsp_t;

    // Rainbow wheel, position 0..255 -> packed {r,g,b}.
    function automatic logic [23:0] wheel(input logic [7:0] pos);
        logic [7:0] p;
        logic [9:0] t;
        begin
            if (pos < 8'd85)
            begin
                t = {2'b0, pos} * 10'd3;
                wheel = {t[7:0], 8'd255 - t[7:0], 8'd0};
            end
            else if (pos < 8'd170)
            begin
                p = pos - 8'd85;
                t = {2'b0, p} * 10'd3;
                wheel = {8'd255 - t[7:0], 8'd0, t[7:0]};
            end
            else
            begin
                p = pos - 8'd170;
                if (p > 8'd85)
                begin
                    p = 8'd85;
                end
                t = {2'b0, p} * 10'd3;
                wheel = {8'd0, t[7:0], 8'd255 - t[7:0]};
            end
        end
    endfunction
endpackage
`default_nettype wire

// ----- design/arbm_div.sv -----
// Module: restoring divider, one quotient bit per cycle.
`default_nettype none
module arbm_div
    import arbm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic [15:0] quot_reg, quot_next;
    logic [11:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [10:0] den_reg, den_next;
    logic [11:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        trial     = {rem_reg[10:0], quot_reg[15]};
        if (req.start)
        begin
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp = '{busy: busy_reg, done: done_reg, quot: quot_reg};
endmodule
`default_nettype wire

// ----- design/auto_ranging_audio_bar_meter_unit.sv -----
// Module: auto-ranging audio bar meter, top level.
// Flow: the sample word is taken in IDLE; a height divide runs when max average > min average,
// and a position divide runs for each lit LED on a multi-LED strip before its word leaves.
// Each LED word leaves when the output is open; then the window scan and averager update;
// one sample at a time.
// Reset: clearing pass over the window; registers to led_count 16, center trim 0, floor 10.
`default_nettype none
module auto_ranging_audio_bar_meter_unit
    import arbm_pkg::*;
#(
    parameter int unsigned WINDOW_SIZE = 64,
    parameter int unsigned MAX_LEDS    = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // sample input: tdata[9:0] mic_sample, rest zero
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,
    // LED output: tdata[5:0] led_index, [13:6] red, [21:14] green,
    // [29:22] blue, [36:30] bar_height, rest zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,
    output logic             m_tlast
);
    localparam int unsigned PtrW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int unsigned CntW = $clog2(WINDOW_SIZE + 1);

    // ---------------- configuration ----------------
    logic [6:0] led_count_reg;
    logic [6:0] center_trim_reg;
    logic [8:0] noise_floor_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg   <= 7'd16;
            center_trim_reg <= 7'd0;
            noise_floor_reg <= 9'd10;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_LED_COUNT:   led_count_reg   <= pwdata[6:0];
                REG_CENTER_TRIM: center_trim_reg <= pwdata[6:0];
                REG_NOISE_FLOOR: noise_floor_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LED_COUNT:   prdata = {25'd0, led_count_reg};
            REG_CENTER_TRIM: prdata = {25'd0, center_trim_reg};
            REG_NOISE_FLOOR: prdata = {23'd0, noise_floor_reg};
            default:         prdata = '0;
        endcase
    end

    // clamped count and scale top
    logic [6:0] count;
    logic [6:0] top;
    assign count = (led_count_reg > 7'(MAX_LEDS)) ? 7'(MAX_LEDS) : led_count_reg;
    assign top   = count + 7'd2;

    // ---------------- window memory ----------------
    logic [SampleW-1:0] win_mem [WINDOW_SIZE];
    logic               mem_we;
    logic [PtrW-1:0]    mem_waddr;
    logic [SampleW-1:0] mem_wdata;
    logic [PtrW-1:0]    mem_raddr;
    logic [SampleW-1:0] mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= win_mem[mem_raddr];
    end

    // ---------------- state ----------------
    state_t state_reg, state_next;
    logic [SampleW-1:0] smooth_reg;
    logic [PtrW-1:0]    wptr_reg;
    logic [AvgW-1:0]    min_avg_reg, max_avg_reg;
    logic [SampleW-1:0] mag_reg;
    logic [HeightW-1:0] height_reg;
    logic [CntW-1:0]    scan_reg;       // clear / scan counter
    logic [SampleW-1:0] lo_reg, hi_reg;
    logic [5:0]         led_reg;        // current LED index
    logic               pos_wait_reg;   // position divide in flight for this LED
    logic               pos_rdy_reg;    // position quotient held for this LED
    logic [6:0]         pos_q_reg;
    logic               frac_neg_reg;

    // output register
    logic       ovalid_reg;
    logic [39:0] odata_reg;
    logic       olast_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    arbm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // ---- front end (combinational, one add chain) ----
    logic signed [11:0] centred;
    logic        [10:0] absmag;
    logic        [SampleW-1:0] n_val;
    logic        [12:0] smooth_sum;
    logic        [SampleW-1:0] smooth_new;
    assign centred = $signed({2'b0, s_tdata[9:0]}) - 12'sd512
                     - {{5{center_trim_reg[6]}}, center_trim_reg};
    assign absmag  = centred[11] ? 11'(-centred) : centred[10:0];
    assign n_val   = (absmag <= {2'b0, noise_floor_reg}) ? '0
                     : SampleW'(absmag - {2'b0, noise_floor_reg});
    assign smooth_sum = {3'b0, smooth_reg} * 13'd7 + {3'b0, n_val};
    assign smooth_new = smooth_sum[12:3];

    // ---- height numerator: top * (smoothed - min) ----
    logic signed [11:0] diff_s;
    logic        [10:0] diff_abs;
    logic        [17:0] prod;
    logic        [AvgW-1:0] den;
    logic               den_pos;
    assign diff_s   = $signed({2'b0, smooth_reg}) - $signed({1'b0, min_avg_reg});
    assign diff_abs = diff_s[11] ? 11'(-diff_s) : diff_s[10:0];
    assign prod     = {11'd0, top} * {7'd0, diff_abs};
    assign den_pos  = max_avg_reg > min_avg_reg;
    assign den      = max_avg_reg - min_avg_reg;

    // ---- LED colour ----
    logic        lit;
    logic        need_pos;          // lit LED on a multi-LED strip needs its wheel position
    logic [23:0] rgb;
    logic [7:0]  pos;
    assign lit      = {1'b0, led_reg} < height_reg;
    assign need_pos = lit && (count > 7'd1);
    assign pos      = (count > 7'd1) ? {1'b0, pos_q_reg} + 8'd30 : 8'd30;
    assign rgb      = wheel(pos);

    // ---- scan/averagers ----
    logic [SampleW:0]   hi_cl;
    logic [17:0]        min_sum, max_sum;
    assign hi_cl   = ({1'b0, hi_reg} - {1'b0, lo_reg} < {4'd0, top})
                     ? {1'b0, lo_reg} + {4'd0, top} : {1'b0, hi_reg};
    assign min_sum = {7'd0, min_avg_reg} * 18'd63 + {8'd0, lo_reg};
    assign max_sum = {7'd0, max_avg_reg} * 18'd63 + {7'd0, hi_cl};

    logic s_acc, m_free;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_free   = !ovalid_reg || m_tready;

    logic last_scan;
    assign last_scan = (scan_reg == CntW'(WINDOW_SIZE - 1));

    // an LED word leaves when the output is open and its colour is known
    logic emit_go;
    assign emit_go = (state_reg == ST_EMIT) && m_free && (!need_pos || pos_rdy_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (last_scan) state_next = ST_IDLE;
            ST_IDLE:  if (s_acc) state_next = ST_FRONT;
            ST_FRONT: state_next = den_pos ? ST_DIV : (count == 7'd0 ? ST_WRITE : ST_EMIT);
            ST_DIV:   if (drsp.done) state_next = (count == 7'd0) ? ST_WRITE : ST_EMIT;
            ST_EMIT:
                if (emit_go && {1'b0, led_reg} == count - 7'd1)
                    state_next = ST_WRITE;
            ST_WRITE: state_next = ST_SCAN;
            ST_SCAN:  if (scan_reg == CntW'(WINDOW_SIZE)) state_next = ST_AVG;
            ST_AVG:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        dreq      = '{start: 1'b0, num: '0, den: '0};
        mem_we    = 1'b0;
        mem_waddr = wptr_reg;
        mem_wdata = mag_reg;
        mem_raddr = scan_reg[PtrW-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg[PtrW-1:0];
                mem_wdata = '0;
            end
            ST_FRONT:
                if (den_pos)
                begin
                    dreq = '{start: 1'b1, num: 16'(prod), den: den};
                end
            ST_EMIT:
                if (need_pos && !pos_wait_reg && !pos_rdy_reg && !drsp.busy)
                begin
                    dreq = '{start: 1'b1, num: 16'({1'b0, led_reg} * 13'd120),
                             den: 11'(count - 7'd1)};
                end
            ST_WRITE: mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            smooth_reg   <= '0;
            wptr_reg     <= '0;
            min_avg_reg  <= '0;
            max_avg_reg  <= AvgW'(512);
            scan_reg     <= '0;
            led_reg      <= '0;
            pos_wait_reg <= 1'b0;
            pos_rdy_reg  <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_go)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: scan_reg <= last_scan ? '0 : scan_reg + 1'b1;
                ST_IDLE:
                    if (s_acc)
                    begin
                        smooth_reg <= smooth_new;
                    end
                ST_FRONT:
                begin
                    led_reg      <= '0;
                    pos_wait_reg <= 1'b0;
                    pos_rdy_reg  <= 1'b0;
                end
                ST_EMIT:
                begin
                    // quotient is held until the output opens
                    if (dreq.start)
                    begin
                        pos_wait_reg <= 1'b1;
                    end
                    else if (pos_wait_reg && drsp.done)
                    begin
                        pos_wait_reg <= 1'b0;
                        pos_rdy_reg  <= 1'b1;
                    end
                    else if (emit_go)
                    begin
                        pos_rdy_reg <= 1'b0;
                        led_reg     <= led_reg + 6'd1;
                    end
                end
                ST_WRITE:
                begin
                    wptr_reg <= (wptr_reg == PtrW'(WINDOW_SIZE - 1)) ? '0 : wptr_reg + 1'b1;
                    scan_reg <= '0;
                end
                ST_SCAN: scan_reg <= scan_reg + 1'b1;
                ST_AVG:
                begin
                    min_avg_reg <= min_sum[16:6];
                    max_avg_reg <= max_sum[16:6];
                end
                default: ;
            endcase
        end
    end

    // payload registers
    logic [15:0] q_clip;
    always_comb
    begin
        q_clip = drsp.quot;
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            mag_reg <= n_val;
        end
        if (state_reg == ST_FRONT)
        begin
            height_reg   <= top;
            frac_neg_reg <= diff_s[11];
        end
        if (state_reg == ST_DIV && drsp.done)
        begin
            if (frac_neg_reg)
                height_reg <= '0;
            else if (q_clip > {9'd0, top})
                height_reg <= top;
            else
                height_reg <= q_clip[6:0];
        end
        if (state_reg == ST_EMIT && pos_wait_reg && drsp.done)
        begin
            pos_q_reg <= drsp.quot[6:0];
        end
        if (emit_go)
        begin
            odata_reg <= {3'd0, height_reg, lit ? rgb[7:0] : 8'd0,
                          lit ? rgb[15:8] : 8'd0, lit ? rgb[23:16] : 8'd0, led_reg};
            olast_reg <= ({1'b0, led_reg} == count - 7'd1);
        end
        // scan: read data arrives in the cycle after its address
        if (state_reg == ST_SCAN)
        begin
            if (scan_reg == CntW'(1))
            begin
                lo_reg <= mem_rdata_reg;
                hi_reg <= mem_rdata_reg;
            end
            else if (scan_reg != '0)
            begin
                if (mem_rdata_reg < lo_reg)
                    lo_reg <= mem_rdata_reg;
                else if (mem_rdata_reg > hi_reg)
                    hi_reg <= mem_rdata_reg;
            end
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
endmodule
`default_nettype wire

// ----- design/arbm_checker.sv -----
// Module: port-level checker for the bar meter, with bind.
`default_nettype none
`include "auto_ranging_audio_bar_meter_unit_assert.svh"
module arbm_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);
    `ARBM_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word dropped while stalled")
    `ARBM_ASSERT_IMP(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[39:37] == 3'd0, "output padding not zero")
    `ARBM_ASSERT_IMP(a_height_range, clk, rst_n, m_tvalid, m_tdata[36:30] <= 7'd66, "bar height out of range")
    `ARBM_ASSERT_NXT(a_one_in, clk, rst_n, s_tvalid && s_tready, !s_tready, "two samples back to back")
endmodule
bind auto_ranging_audio_bar_meter_unit arbm_checker u_arbm_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
